/* rtl/knn_pkg.sv */
// ----------------------------------------------------------------------------
// knn_pkg: shared types and constants of the k-nearest-neighbor search
// Word formats, configuration register indexes, result status codes and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package knn_pkg;

    localparam int K_MAX          = 16;
    localparam int COORD_BITS     = 16;
    localparam int INDEX_BITS     = 16;
    localparam int DIST_BITS      = 40;
    localparam int KREG_BITS      = 5;
    localparam int CFG_INDEX_BITS = 2;
    localparam int RANK_BITS      = $clog2(K_MAX);
    localparam int CNT_BITS       = $clog2(K_MAX + 1);
    localparam int DIFF_BITS      = COORD_BITS + 1;
    localparam int SQ_BITS        = 2 * DIFF_BITS;

    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_K_COUNT        = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RADIUS_ENABLE  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RADIUS_SQ      = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ACCEPT_PARTIAL = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_NEIGHBOR = 2'd0;
    localparam logic [1:0] ST_PARTIAL  = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] query_coord;
        logic signed [COORD_BITS-1:0] point_coord;
        logic [INDEX_BITS-1:0]        point_index;
        logic                         last_coord;
        logic                         last_point;
    } knn_in_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0] neighbor_index;
        logic [DIST_BITS-1:0]  sq_distance;
        logic [RANK_BITS-1:0]  rank;
        logic [1:0]            status;
        logic                  last;
    } knn_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_ACCUM,
        S_INSERT,
        S_LOAD,
        S_OUT
    } knn_state_t;

    typedef struct packed {
        logic load_in;
        logic square;
        logic accum;
        logic insert;
        logic load_out;
        logic first;
    } knn_cmd_t;

    typedef struct packed {
        logic last_coord;
        logic last_point;
        logic out_last;
    } knn_stat_t;

endpackage

/* rtl/knn_ctrl.sv */
// ----------------------------------------------------------------------------
// knn_ctrl: sequencing controller of the k-nearest-neighbor search
// Steps each input word through square, accumulate and list insertion, and
// walks the result words out of the datapath at the end of a query.
// ----------------------------------------------------------------------------
module knn_ctrl
    import knn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  knn_stat_t stat,
    output knn_cmd_t  cmd
);

    knn_state_t state_reg;
    knn_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                state_next = S_ACCUM;
            end
            S_ACCUM:
            begin
                state_next = stat.last_coord ? S_INSERT : S_IDLE;
            end
            S_INSERT:
            begin
                state_next = stat.last_point ? S_LOAD : S_IDLE;
            end
            S_LOAD:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready && stat.out_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            S_SQUARE:
            begin
                cmd.square = 1'b1;
            end
            S_ACCUM:
            begin
                cmd.accum = 1'b1;
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
            end
            S_LOAD:
            begin
                cmd.load_out = 1'b1;
                cmd.first    = 1'b1;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                // The next result word is fetched as the current one is taken.
                cmd.load_out = out_ready && !stat.out_last;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input accepted while a result word is pending");

    a_load_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |=> (state_reg == S_OUT))
        else $error("first result word not presented after load");

    a_end_of_query: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && stat.out_last) |=> in_ready)
        else $error("controller did not return to idle after the final word");

endmodule

/* rtl/knn_dpath.sv */
// ----------------------------------------------------------------------------
// knn_dpath: datapath of the k-nearest-neighbor search
// Holds the configuration registers, squares and accumulates coordinate
// differences, keeps the sorted top-k list and forms the result words.
// ----------------------------------------------------------------------------
module knn_dpath
    import knn_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  knn_cmd_t                  cmd,
    output knn_stat_t                 stat,
    input  knn_in_t                   in_data,
    output knn_out_t                  out_data,
    input  logic                      cfg_valid,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [DIST_BITS-1:0]      cfg_data
);

    // Configuration registers.
    logic [KREG_BITS-1:0] k_count_reg;
    logic                 radius_enable_reg;
    logic [DIST_BITS-1:0] radius_sq_reg;
    logic                 accept_partial_reg;

    // Control state.
    logic [DIST_BITS-1:0] dist_accum_reg;
    logic [DIST_BITS-1:0] dist_accum_next;
    logic [CNT_BITS-1:0]  found_count_reg;
    logic [CNT_BITS-1:0]  found_count_next;
    logic [CNT_BITS-1:0]  emit_count_reg;
    logic [CNT_BITS-1:0]  emit_count_next;
    logic [RANK_BITS-1:0] rank_reg;
    logic [RANK_BITS-1:0] rank_next;

    // Payload.
    knn_in_t              in_reg;
    logic [SQ_BITS-1:0]   sq_reg;
    knn_out_t             out_reg;
    knn_out_t             out_next;
    logic [DIST_BITS-1:0]  best_dists_reg   [K_MAX];
    logic [DIST_BITS-1:0]  best_dists_next  [K_MAX];
    logic [INDEX_BITS-1:0] best_indices_reg [K_MAX];
    logic [INDEX_BITS-1:0] best_indices_next[K_MAX];

    logic signed [DIFF_BITS-1:0] diff;
    logic [DIFF_BITS-1:0]        mag;
    logic [DIST_BITS:0]          sum;
    logic [CNT_BITS-1:0]         k_eff;
    logic [CNT_BITS-1:0]         km1_full;
    logic [RANK_BITS-1:0]        km1;
    logic [CNT_BITS-1:0]         n_cur;
    logic [CNT_BITS-1:0]         n_after;
    logic [CNT_BITS-1:0]         region;
    logic                        keep;
    logic                        room;
    logic                        do_insert;
    logic [K_MAX-1:0]            cmp;
    logic [K_MAX-1:0]            lt;
    logic [K_MAX-1:0]            lt_prev;
    logic [K_MAX-1:0]            new_here;
    logic [RANK_BITS-1:0]        rank_cur;
    logic                        reject;

    // Squared difference of one coordinate pair.
    assign diff = DIFF_BITS'(in_reg.query_coord) - DIFF_BITS'(in_reg.point_coord);
    assign mag  = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
    assign sum  = {1'b0, dist_accum_reg} + (DIST_BITS + 1)'(sq_reg);

    // A k of zero acts as one, and one above the list size as the list size.
    always_comb
    begin
        if (k_count_reg == '0)
        begin
            k_eff = CNT_BITS'(1);
        end
        else if (k_count_reg > KREG_BITS'(K_MAX))
        begin
            k_eff = CNT_BITS'(K_MAX);
        end
        else
        begin
            k_eff = CNT_BITS'(k_count_reg);
        end
    end

    assign km1_full = k_eff - CNT_BITS'(1);
    assign km1      = km1_full[RANK_BITS-1:0];
    assign n_cur    = (found_count_reg < k_eff) ? found_count_reg : k_eff;
    assign room     = n_cur < k_eff;
    // With a full list the search covers the first k-1 places; failing those, the entry replaces place k-1.
    assign region   = room ? n_cur : km1_full;
    assign keep     = !(radius_enable_reg && (dist_accum_reg > radius_sq_reg));

    // Parallel compare of the finished distance against every list entry.
    always_comb
    begin
        for (int j = 0; j < K_MAX; j++)
        begin
            cmp[j] = dist_accum_reg < best_dists_reg[j];
            lt[j]  = cmp[j] && (CNT_BITS'(j) < region);
        end
        lt_prev = {lt[K_MAX-2:0], 1'b0};
        for (int j = 0; j < K_MAX; j++)
        begin
            new_here[j] = (CNT_BITS'(j) <= region) && !lt_prev[j]
                          && ((CNT_BITS'(j) == region) || lt[j]);
        end
    end

    assign do_insert = keep && (room || cmp[km1]);
    assign n_after   = (do_insert && room) ? n_cur + CNT_BITS'(1) : n_cur;

    always_comb
    begin
        for (int j = 0; j < K_MAX; j++)
        begin
            best_dists_next[j]   = best_dists_reg[j];
            best_indices_next[j] = best_indices_reg[j];
        end
        if (cmd.insert && do_insert)
        begin
            for (int j = 0; j < K_MAX; j++)
            begin
                if (new_here[j])
                begin
                    best_dists_next[j]   = dist_accum_reg;
                    best_indices_next[j] = in_reg.point_index;
                end
            end
            // Entries behind the insertion point move down by one place.
            for (int j = 1; j < K_MAX; j++)
            begin
                if (lt_prev[j])
                begin
                    best_dists_next[j]   = best_dists_reg[j-1];
                    best_indices_next[j] = best_indices_reg[j-1];
                end
            end
        end
        else if (cmd.load_out)
        begin
            // The list drains toward entry zero as the words go out.
            for (int j = 0; j < K_MAX - 1; j++)
            begin
                best_dists_next[j]   = best_dists_reg[j+1];
                best_indices_next[j] = best_indices_reg[j+1];
            end
        end
    end

    always_comb
    begin
        dist_accum_next  = dist_accum_reg;
        found_count_next = found_count_reg;
        emit_count_next  = emit_count_reg;
        if (cmd.accum)
        begin
            dist_accum_next = sum[DIST_BITS] ? DIST_MAX : sum[DIST_BITS-1:0];
        end
        else if (cmd.insert)
        begin
            dist_accum_next  = '0;
            found_count_next = in_reg.last_point ? '0 : n_after;
            if (in_reg.last_point)
            begin
                emit_count_next = n_after;
            end
        end
    end

    assign rank_cur = cmd.first ? '0 : rank_reg + RANK_BITS'(1);
    assign reject   = radius_enable_reg && !accept_partial_reg && (emit_count_reg < k_eff);

    always_comb
    begin
        rank_next = rank_reg;
        out_next  = out_reg;
        if (cmd.load_out)
        begin
            rank_next = rank_cur;
            if (cmd.first && reject)
            begin
                out_next = '{neighbor_index: '0, sq_distance: '0, rank: '0,
                             status: ST_PARTIAL, last: 1'b1};
            end
            else if (cmd.first && (emit_count_reg == '0))
            begin
                out_next = '{neighbor_index: '0, sq_distance: '0, rank: '0,
                             status: ST_EMPTY, last: 1'b1};
            end
            else
            begin
                out_next = '{neighbor_index: best_indices_reg[0],
                             sq_distance: best_dists_reg[0],
                             rank: rank_cur,
                             status: ST_NEIGHBOR,
                             last: (CNT_BITS'(rank_cur) + CNT_BITS'(1)) == emit_count_reg};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_count_reg        <= KREG_BITS'(1);
            radius_enable_reg  <= 1'b0;
            radius_sq_reg      <= '0;
            accept_partial_reg <= 1'b0;
            dist_accum_reg     <= '0;
            found_count_reg    <= '0;
            emit_count_reg     <= '0;
            rank_reg           <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_K_COUNT:        k_count_reg        <= cfg_data[KREG_BITS-1:0];
                    CFG_RADIUS_ENABLE:  radius_enable_reg  <= cfg_data[0];
                    CFG_RADIUS_SQ:      radius_sq_reg      <= cfg_data;
                    CFG_ACCEPT_PARTIAL: accept_partial_reg <= cfg_data[0];
                    default:            k_count_reg        <= k_count_reg;
                endcase
            end
            dist_accum_reg  <= dist_accum_next;
            found_count_reg <= found_count_next;
            emit_count_reg  <= emit_count_next;
            rank_reg        <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_reg <= in_data;
        end
        if (cmd.square)
        begin
            sq_reg <= SQ_BITS'(mag) * SQ_BITS'(mag);
        end
        out_reg <= out_next;
        for (int j = 0; j < K_MAX; j++)
        begin
            best_dists_reg[j]   <= best_dists_next[j];
            best_indices_reg[j] <= best_indices_next[j];
        end
    end

    assign stat.last_coord = in_reg.last_coord;
    assign stat.last_point = in_reg.last_point;
    assign stat.out_last   = out_reg.last;
    assign out_data        = out_reg;

    a_found_bound: assert property (@(posedge clk) disable iff (!rst_n)
        found_count_reg <= CNT_BITS'(K_MAX))
        else $error("neighbor count exceeds the list size");

    a_query_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.insert && in_reg.last_point) |=> (found_count_reg == '0 && dist_accum_reg == '0))
        else $error("query state not cleared at the end of a query");

endmodule

/* rtl/knn_topk_radius_search.sv */
// ----------------------------------------------------------------------------
// knn_topk_radius_search: top-k nearest neighbor search with radius limit
// Streams coordinate pairs of one query, keeps the k nearest candidates by
// squared Euclidean distance and emits them in ascending order.
// ----------------------------------------------------------------------------
// Each input word (one coordinate pair) is accepted in IDLE, squared 17 by 17
// bits in SQUARE and added in ACCUM by the saturating 40-bit accumulate; the
// next word is accepted only after ACCUM. The final coordinate of a candidate
// adds INSERT, the parallel compare-and-shift insertion into the 16-entry list,
// and the final candidate of a query adds LOAD to fetch the first result word;
// after that the result words leave at one per cycle while out_ready is high.
// New input words are taken only after the last result word of the query has
// been delivered. Configuration writes are always ready and take effect in
// the next cycle.
module knn_topk_radius_search
    import knn_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  knn_in_t                   in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output knn_out_t                  out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [DIST_BITS-1:0]      cfg_data
);

    knn_cmd_t  cmd;
    knn_stat_t stat;

    assign cfg_ready = 1'b1;

    knn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    knn_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
